/* design/scp_pkg.sv */
// ----------------------------------------------------------------------------
// scp_pkg: shared definitions for the sync/CRC-8 frame parser
// Holds the register map, status codes, frame constants and the control
// structs that pass between the frame controller and the serial CRC unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

  // Configuration port geometry and register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'd1;

  // Reset values of the sync registers
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

  // CRC-8: polynomial x^8 + x^2 + x + 1, MSB first, init zero
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_TOP  = 8'h80;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // Frame body: four payload bytes then the check byte
  localparam logic [2:0] FRAME_DATA_LEN = 3'd4;
  localparam logic [2:0] FRAME_BODY_LEN = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_GOOD = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Receive phase, one-hot
  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_SYNC1   = 3'b010,
    PH_COLLECT = 3'b100
  } phase_t;

  // Controller to CRC unit
  typedef struct packed {
    logic       clear;
    logic       start;
    logic [7:0] data;
  } crc_ctrl_t;

  // CRC unit to controller
  typedef struct packed {
    logic       busy;
    logic [7:0] crc;
  } crc_stat_t;

endpackage

`default_nettype wire

/* design/scp_if.sv */
// ----------------------------------------------------------------------------
// scp_in_if / scp_out_if: valid/ready channels of the frame parser
// Input channel carries one received byte; output channel carries one
// status transaction per received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface scp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  frame_type;
  logic [7:0]  node_id;
  logic [15:0] sequence_res;

  modport source (output valid, output status, output frame_type, output node_id,
                  output sequence_res, input ready);
  modport sink   (input valid, input status, input frame_type, input node_id,
                  input sequence_res, output ready);
endinterface

`default_nettype wire

/* design/scp_crc_ser.sv */
// ----------------------------------------------------------------------------
// scp_crc_ser: bit-serial CRC-8 engine
// Folds one payload byte into the running CRC with one polynomial step per
// cycle: the byte is XORed in on start, then eight shift steps follow.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_crc_ser
  import scp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire crc_ctrl_t ctrl,
  output crc_stat_t      stat
);

  logic [7:0] crc;
  logic [7:0] crc_next;
  logic [2:0] step;
  logic       busy;

  // One polynomial division step, MSB first
  always_comb begin
    if ((crc & CRC_TOP) != 8'h00) begin
      crc_next = {crc[6:0], 1'b0} ^ CRC_POLY;
    end else begin
      crc_next = {crc[6:0], 1'b0};
    end
  end

  // Load, clear and advance the shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      crc  <= CRC_INIT;
      step <= 3'd0;
      busy <= 1'b0;
    end else if (ctrl.clear) begin
      crc  <= CRC_INIT;
      step <= 3'd0;
      busy <= 1'b0;
    end else if (ctrl.start) begin
      crc  <= crc ^ ctrl.data;
      step <= 3'd0;
      busy <= 1'b1;
    end else if (busy) begin
      crc  <= crc_next;
      step <= step + 3'd1;
      if (step == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.crc  = crc;

endmodule

`default_nettype wire

/* design/sync_crc8_frame_parser.sv */
// ----------------------------------------------------------------------------
// sync_crc8_frame_parser: two-byte sync frame parser with CRC-8 check
// Hunts for the sync pair, collects type, node id, sequence low/high and
// a CRC-8 check byte, and reports one status transaction per byte.
// ----------------------------------------------------------------------------
// Every accepted byte yields one result, registered and offered on the
// output channel the cycle after acceptance. Sync and check bytes do not
// start the serial unit. A payload byte is folded into the CRC by a
// bit-serial unit at one bit per cycle, so the next byte is taken only
// after the load and the eight shift steps. The input also waits while
// a result sits untaken in the output register. The sync bytes are
// programmable (index 0 first sync, index 1 second sync) and should be
// written only while no byte is in flight.
`default_nettype none

module sync_crc8_frame_parser
  import scp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  scp_in_if.sink                     in_ch,
  scp_out_if.source                  out_ch
);

  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  phase_t      phase;
  phase_t      phase_next;
  logic [2:0]  byte_count;
  logic [2:0]  byte_count_next;
  logic [7:0]  payload_store [4];
  logic        store_we;
  logic        take;
  crc_ctrl_t   crc_ctl;
  crc_stat_t   crc_st;
  logic [1:0]  res_status;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_type;
  logic [7:0]  out_node;
  logic [15:0] out_seq;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data[7:0];
        CFG_SYNC_SECOND: sync_second <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Accept a byte when the CRC unit is idle and the output slot frees up
  assign in_ch.ready = !crc_st.busy && (!out_valid || out_ch.ready);
  assign take        = in_ch.valid && in_ch.ready;

  // Phase decode for the incoming byte
  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    store_we        = 1'b0;
    res_status      = ST_NONE;
    crc_ctl.clear   = 1'b0;
    crc_ctl.start   = 1'b0;
    crc_ctl.data    = in_ch.rx_byte;
    case (phase)
      PH_HUNT: begin
        phase_next = (in_ch.rx_byte == sync_first) ? PH_SYNC1 : PH_HUNT;
      end
      PH_SYNC1: begin
        // second sync is tested before a repeat of the first
        if (in_ch.rx_byte == sync_second) begin
          phase_next      = PH_COLLECT;
          byte_count_next = 3'd0;
          crc_ctl.clear   = take;
        end else if (in_ch.rx_byte == sync_first) begin
          phase_next = PH_SYNC1;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_COLLECT: begin
        if (byte_count < FRAME_DATA_LEN) begin
          store_we        = take;
          crc_ctl.start   = take;
          byte_count_next = byte_count + 3'd1;
        end else begin
          // check byte closes the frame
          phase_next      = PH_HUNT;
          byte_count_next = FRAME_BODY_LEN;
          res_status      = (crc_st.crc == in_ch.rx_byte) ? ST_GOOD : ST_BAD;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // Phase and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_count <= 3'd0;
    end else if (take) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
    end
  end

  // Payload byte store
  always_ff @(posedge clk) begin
    if (store_we) begin
      payload_store[byte_count[1:0]] <= in_ch.rx_byte;
    end
  end

  // Serial CRC unit
  scp_crc_ser u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctl),
    .stat (crc_st)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_status <= res_status;
      if (res_status == ST_GOOD) begin
        out_type <= payload_store[0];
        out_node <= payload_store[1];
        out_seq  <= {payload_store[3], payload_store[2]};
      end else begin
        out_type <= 8'h00;
        out_node <= 8'h00;
        out_seq  <= 16'h0000;
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.frame_type   = out_type;
  assign out_ch.node_id      = out_node;
  assign out_ch.sequence_res = out_seq;

endmodule

`default_nettype wire

/* design/scp_checker.sv */
// ----------------------------------------------------------------------------
// scp_checker: port-level checks for the frame parser
// Watches the channel handshakes and result payload; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_checker
  import scp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [7:0]  frame_type,
  input wire logic [7:0]  node_id,
  input wire logic [15:0] sequence_res
);

  // every accepted byte yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after accepted byte");

  // a stalled result blocks the input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("byte accepted while result stalled");

  // data fields are zero unless the frame is good
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_GOOD) |->
      (frame_type == 8'h00 && node_id == 8'h00 && sequence_res == 16'h0000))
    else $error("data fields set without a good frame");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status)))
    else $error("stalled result changed");

endmodule

bind sync_crc8_frame_parser scp_checker u_scp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .frame_type   (out_ch.frame_type),
  .node_id      (out_ch.node_id),
  .sequence_res (out_ch.sequence_res)
);

`default_nettype wire
